@@ rtl/rtbmp_pkg.sv @@
package rtbmp_pkg;

  // Field widths of the two channels.
  localparam int unsigned INDEX_W        = 63;
  localparam int unsigned TERM_W         = 30;
  localparam int unsigned INDEX_BITS_DEF = 63;

  // Matrix storage: 4x4 entries per matrix, one region of the RAM per matrix.
  localparam int unsigned ENTRY_W     = 4;
  localparam int unsigned REGION_W    = 2;
  localparam int unsigned RAM_ADDR_W  = REGION_W + ENTRY_W;
  localparam int unsigned RAM_DEPTH   = 2 ** RAM_ADDR_W;

  // Modulus and Montgomery constants (R = 2^32).
  localparam int unsigned MONT_W = 32;
  localparam logic [TERM_W-1:0] PRIME = 30'd1000000007;
  localparam logic [TERM_W-1:0] MONT_ONE = TERM_W'(64'h1_0000_0000 % 64'(PRIME));

  // Entries of the identity and of the companion matrix, index row*4+col.
  localparam logic [15:0] IDENT_MASK     = 16'b1000_0100_0010_0001;
  localparam logic [15:0] COMPANION_MASK = 16'b1000_0010_0001_1101;

  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    logic [ENTRY_W-1:0]   tag;
  } mac_ctl_t;

  typedef struct packed {
    logic                 valid;
    logic [ENTRY_W-1:0]   tag;
  } mac_res_t;

  // -p^-1 mod 2^32 by Newton iteration; each pass doubles the correct bits.
  function automatic logic [MONT_W-1:0] mont_pinv();
    logic [MONT_W-1:0] inv;
    logic [MONT_W-1:0] p32;
    p32 = MONT_W'(PRIME);
    inv = p32;
    for (int i = 0; i < 5; i++) begin
      inv = inv * (MONT_W'(2) - p32 * inv);
    end
    return ~inv + MONT_W'(1);
  endfunction

  localparam logic [MONT_W-1:0] MONT_PINV = mont_pinv();

  // Start vector (10, 6, 3, 3) of the final dot product.
  function automatic logic [TERM_W-1:0] start_vec(input logic [1:0] k);
    logic [TERM_W-1:0] v;
    unique case (k)
      2'd0: v = TERM_W'(10);
      2'd1: v = TERM_W'(6);
      2'd2: v = TERM_W'(3);
      2'd3: v = TERM_W'(3);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Terms 0 to 4 are n(n+1)/2.
  function automatic logic [TERM_W-1:0] small_term(input logic [2:0] n);
    logic [TERM_W-1:0] v;
    unique case (n)
      3'd0: v = TERM_W'(0);
      3'd1: v = TERM_W'(1);
      3'd2: v = TERM_W'(3);
      3'd3: v = TERM_W'(6);
      3'd4: v = TERM_W'(10);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Starting matrices in Montgomery form: sel 0 is identity, 1 is companion.
  function automatic logic [TERM_W-1:0] init_entry(input logic sel,
                                                    input logic [ENTRY_W-1:0] idx);
    logic bit_set;
    bit_set = sel ? COMPANION_MASK[idx] : IDENT_MASK[idx];
    return bit_set ? MONT_ONE : '0;
  endfunction

endpackage

@@ rtl/rtbmp_ram.sv @@
module rtbmp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/rtbmp_mont_mac.sv @@
// Pipelined multiply-accumulate with Montgomery reduction (R = 2^32).
// A run of operand pairs from first to last gives one reduced result.
module rtbmp_mont_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rtbmp_pkg::mac_ctl_t             ctl_i,
  input  logic [rtbmp_pkg::TERM_W-1:0]    a_i,
  input  logic [rtbmp_pkg::TERM_W-1:0]    b_i,
  output rtbmp_pkg::mac_res_t             res_o,
  output logic [rtbmp_pkg::TERM_W-1:0]    res_data_o,
  output logic                            busy_o
);

  localparam int unsigned PROD_W = 2 * rtbmp_pkg::TERM_W;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned MW     = rtbmp_pkg::MONT_W;
  localparam int unsigned EW     = rtbmp_pkg::ENTRY_W;

  rtbmp_pkg::mac_ctl_t ctl1_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   prod_d;

  logic                v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [EW-1:0]       tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [MW-1:0]       m_q, m_d;
  logic [ACC_W-1:0]    x1_q, x2_q;
  logic [ACC_W-1:0]    mp_q, mp_d;
  logic [ACC_W:0]      sum_d;
  logic [rtbmp_pkg::TERM_W:0] t_q;
  logic [rtbmp_pkg::TERM_W-1:0] res_q, res_d;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);
  assign acc_d  = (ctl1_q.first ? '0 : acc_q) + ACC_W'(prod_q);
  assign m_d    = acc_q[MW-1:0] * rtbmp_pkg::MONT_PINV;
  assign mp_d   = ACC_W'(m_q) * ACC_W'(rtbmp_pkg::PRIME);
  // The low 32 bits of the sum are zero by construction.
  assign sum_d  = {1'b0, x2_q} + {1'b0, mp_q};
  assign res_d  = (t_q >= {1'b0, rtbmp_pkg::PRIME}) ?
                  rtbmp_pkg::TERM_W'(t_q - {1'b0, rtbmp_pkg::PRIME}) :
                  rtbmp_pkg::TERM_W'(t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      v2_q   <= ctl1_q.valid & ctl1_q.last;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl1_q.valid) begin
      acc_q <= acc_d;
    end
    tag2_q <= ctl1_q.tag;
    m_q    <= m_d;
    x1_q   <= acc_q;
    tag3_q <= tag2_q;
    mp_q   <= mp_d;
    x2_q   <= x1_q;
    tag4_q <= tag3_q;
    t_q    <= sum_d[ACC_W:MW];
    tag5_q <= tag4_q;
    res_q  <= res_d;
    tag6_q <= tag5_q;
  end

  assign res_o.valid = v6_q;
  assign res_o.tag   = tag6_q;
  assign res_data_o  = res_q;
  assign busy_o      = ctl_i.valid | ctl1_q.valid | v2_q | v3_q | v4_q | v5_q | v6_q;

endmodule

@@ rtl/recurrence_term_by_matrix_power.sv @@
// Indices 0 to 4 take the direct path and skip the matrix power.
// Larger indices: the start matrices are loaded, then each 4x4 matrix
// product runs 64 multiply-accumulates on the one shared Montgomery
// unit and then lets the pipeline drain, one or two products per
// exponent bit. One item at a time; the input is not ready while an
// item is in work. Reset clears all control state.
module recurrence_term_by_matrix_power #(
  parameter int unsigned INDEX_BITS = rtbmp_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rtbmp_pkg::INDEX_W-1:0]   n_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rtbmp_pkg::TERM_W-1:0]    term_o
);

  localparam int unsigned TW = rtbmp_pkg::TERM_W;
  localparam int unsigned RW = rtbmp_pkg::REGION_W;
  localparam int unsigned EW = rtbmp_pkg::ENTRY_W;
  localparam int unsigned AW = rtbmp_pkg::RAM_ADDR_W;

  // Starting assignment of the three matrix regions in the RAM.
  localparam logic [RW-1:0] ACC_RGN_INIT   = RW'(0);
  localparam logic [RW-1:0] BASE_RGN_INIT  = RW'(1);
  localparam logic [RW-1:0] SPARE_RGN_INIT = RW'(2);

  localparam logic [5:0] INIT_LAST = 6'd31;
  localparam logic [5:0] MUL_LAST  = 6'd63;
  localparam logic [5:0] DOT_LAST  = 6'd3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_STEP  = 6'b000100,
    S_ISSUE = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  // Which product is running: acc*base, base*base, or the final dot product.
  typedef enum logic [1:0] {
    OP_ACC = 2'd0,
    OP_SQ  = 2'd1,
    OP_DOT = 2'd2
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [5:0]            cnt_q, cnt_d;
  logic [INDEX_BITS-1:0] e_q, e_d;
  logic [INDEX_BITS-1:0] e_shift;
  logic [INDEX_BITS-1:0] n_masked;
  logic                  did_mul_q, did_mul_d;
  logic [RW-1:0]         acc_rgn_q, acc_rgn_d;
  logic [RW-1:0]         base_rgn_q, base_rgn_d;
  logic [RW-1:0]         spare_rgn_q, spare_rgn_d;
  logic [TW-1:0]         res_q, res_d;
  logic [TW-1:0]         term_q;
  logic                  out_valid_q;
  logic                  out_load;
  logic                  in_xfer;

  // Issue-side signals.
  logic          issue;
  logic          issue_last;
  logic [1:0]    ix_i, ix_j, ix_k;
  logic [RW-1:0] a_rgn;

  // Read stage, aligned with the registered RAM data.
  rtbmp_pkg::mac_ctl_t rd_ctl_q;
  logic [1:0]          rd_k_q;
  logic                rd_vec_q;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [TW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr_a, ram_raddr_b;
  logic [TW-1:0] ram_rdata_a, ram_rdata_b;

  // Multiply-accumulate unit.
  logic [TW-1:0]       mac_b;
  rtbmp_pkg::mac_res_t mac_res;
  logic [TW-1:0]       mac_data;
  logic                mac_busy;
  logic                in_flight;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign n_masked   = n_index_i[INDEX_BITS-1:0];
  assign e_shift    = e_q >> 1;

  // The dot product walks row 0 of the accumulator; products walk i, j, k.
  assign issue      = (state_q == S_ISSUE);
  assign ix_k       = cnt_q[1:0];
  assign ix_j       = (op_q == OP_DOT) ? 2'd0 : cnt_q[3:2];
  assign ix_i       = (op_q == OP_DOT) ? 2'd0 : cnt_q[5:4];
  assign issue_last = (op_q == OP_DOT) ? (cnt_q == DOT_LAST) : (cnt_q == MUL_LAST);
  assign a_rgn      = (op_q == OP_SQ) ? base_rgn_q : acc_rgn_q;

  assign ram_raddr_a = {a_rgn, ix_i, ix_k};
  assign ram_raddr_b = {base_rgn_q, ix_k, ix_j};

  // Writes come from the start-matrix load or from finished product entries,
  // which always land in the spare region.
  always_comb begin
    if (state_q == S_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = {(cnt_q[4] ? base_rgn_q : acc_rgn_q), cnt_q[EW-1:0]};
      ram_wdata = rtbmp_pkg::init_entry(cnt_q[4], cnt_q[EW-1:0]);
    end else begin
      ram_we    = mac_res.valid & (op_q != OP_DOT);
      ram_waddr = {spare_rgn_q, mac_res.tag};
      ram_wdata = mac_data;
    end
  end

  assign mac_b     = rd_vec_q ? rtbmp_pkg::start_vec(rd_k_q) : ram_rdata_b;
  assign in_flight = mac_busy;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    e_d         = e_q;
    did_mul_d   = did_mul_q;
    acc_rgn_d   = acc_rgn_q;
    base_rgn_d  = base_rgn_q;
    spare_rgn_d = spare_rgn_q;
    res_d       = res_q;
    out_load    = 1'b0;

    if (mac_res.valid && op_q == OP_DOT) begin
      res_d = mac_data;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cnt_d       = '0;
          did_mul_d   = 1'b0;
          acc_rgn_d   = ACC_RGN_INIT;
          base_rgn_d  = BASE_RGN_INIT;
          spare_rgn_d = SPARE_RGN_INIT;
          e_d         = n_masked - INDEX_BITS'(4);
          if (n_masked <= INDEX_BITS'(4)) begin
            res_d   = rtbmp_pkg::small_term(n_masked[2:0]);
            state_d = S_FIN;
          end else begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == INIT_LAST) begin
          cnt_d   = '0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cnt_d   = '0;
        state_d = S_ISSUE;
        priority if (e_q[0] && !did_mul_q) begin
          op_d      = OP_ACC;
          did_mul_d = 1'b1;
        end else if (e_shift != '0) begin
          op_d      = OP_SQ;
          e_d       = e_shift;
          did_mul_d = 1'b0;
        end else begin
          op_d = OP_DOT;
        end
      end
      S_ISSUE: begin
        cnt_d = cnt_q + 6'd1;
        if (issue_last) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The next product may read what this one wrote, so wait until the
        // last entry has gone into the RAM, then rename the regions.
        if (!in_flight) begin
          unique case (op_q)
            OP_ACC: begin
              acc_rgn_d   = spare_rgn_q;
              spare_rgn_d = acc_rgn_q;
              state_d     = S_STEP;
            end
            OP_SQ: begin
              base_rgn_d  = spare_rgn_q;
              spare_rgn_d = base_rgn_q;
              state_d     = S_STEP;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        // Wait for the output register to be free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ACC;
      cnt_q       <= '0;
      did_mul_q   <= 1'b0;
      acc_rgn_q   <= ACC_RGN_INIT;
      base_rgn_q  <= BASE_RGN_INIT;
      spare_rgn_q <= SPARE_RGN_INIT;
      out_valid_q <= 1'b0;
      rd_ctl_q    <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      did_mul_q   <= did_mul_d;
      acc_rgn_q   <= acc_rgn_d;
      base_rgn_q  <= base_rgn_d;
      spare_rgn_q <= spare_rgn_d;
      out_valid_q <= (out_valid_q & ~out_ready_i) | out_load;
      rd_ctl_q.valid <= issue;
      rd_ctl_q.first <= (ix_k == 2'd0);
      rd_ctl_q.last  <= (ix_k == 2'd3);
      rd_ctl_q.tag   <= {ix_i, ix_j};
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    res_q    <= res_d;
    rd_k_q   <= ix_k;
    rd_vec_q <= (op_q == OP_DOT);
    if (out_load) begin
      term_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign term_o      = term_q;

  rtbmp_ram #(
    .WIDTH (TW),
    .DEPTH (rtbmp_pkg::RAM_DEPTH)
  ) u_mat_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  rtbmp_mont_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rd_ctl_q),
    .a_i        (ram_rdata_a),
    .b_i        (mac_b),
    .res_o      (mac_res),
    .res_data_o (mac_data),
    .busy_o     (mac_busy)
  );

endmodule

@@ sim/tb_recurrence_term_by_matrix_power.sv @@
`timescale 1ns / 1ps

module tb_recurrence_term_by_matrix_power;

  localparam int unsigned INDEX_W    = rtbmp_pkg::INDEX_W;
  localparam int unsigned TERM_W     = rtbmp_pkg::TERM_W;
  localparam int unsigned INDEX_BITS = rtbmp_pkg::INDEX_BITS_DEF;

  // The prime modulus of the recurrence, kept at 64 bits for the predictor.
  localparam logic [63:0] MODULUS = 64'd1000000007;

  // A 4x4 matrix held as 16 packed entries, index row*4+col.
  typedef logic [15:0][TERM_W-1:0] mat_t;

  typedef struct {
    logic [INDEX_W-1:0] n;
    logic [TERM_W-1:0]  term;
  } term_exp_t;

  logic                 clk = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [INDEX_W-1:0]   n_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [TERM_W-1:0]    term_o;

  term_exp_t            expected_terms[$];
  int unsigned          mismatch_cnt = 0;
  int unsigned          ready_hold;
  bit                   no_idle;

  recurrence_term_by_matrix_power #(
    .INDEX_BITS(INDEX_BITS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .n_index_i  (n_index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .term_o     (term_o)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: term n of d(i) = d(i-1) + d(i-3) + 3 modulo the prime.
  // ---------------------------------------------------------------------------

  function automatic mat_t mat_mul_mod(input mat_t a, input mat_t b);
    mat_t        r;
    logic [63:0] acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        // Entries stay below 2^30, so four products fit easily in 64 bits.
        for (int k = 0; k < 4; k++) begin
          acc += 64'(a[i*4+k]) * 64'(b[k*4+j]);
        end
        r[i*4+j] = TERM_W'(acc % MODULUS);
      end
    end
    return r;
  endfunction

  function automatic logic [TERM_W-1:0] predict_term(input logic [INDEX_W-1:0] n_raw);
    logic [63:0] n;
    logic [63:0] expo;
    logic [63:0] dot;
    mat_t        power;
    mat_t        base;
    n = 64'(n_raw);
    if (INDEX_BITS < 64) begin
      n &= (64'd1 << INDEX_BITS) - 64'd1;
    end
    // Terms 0 to 4 come straight from n(n+1)/2.
    if (n <= 64'd4) begin
      return TERM_W'((n * (n + 64'd1)) / 64'd2);
    end
    power = '0;
    base  = '0;
    for (int i = 0; i < 4; i++) begin
      power[i*5] = TERM_W'(1);
    end
    // Companion matrix {1,0,1,1; 1,0,0,0; 0,1,0,0; 0,0,0,1}.
    base[0]  = TERM_W'(1);
    base[2]  = TERM_W'(1);
    base[3]  = TERM_W'(1);
    base[4]  = TERM_W'(1);
    base[9]  = TERM_W'(1);
    base[15] = TERM_W'(1);
    expo = n - 64'd4;
    while (expo != 0) begin
      if (expo[0]) begin
        power = mat_mul_mod(power, base);
      end
      expo >>= 1;
      if (expo != 0) begin
        base = mat_mul_mod(base, base);
      end
    end
    // Row 0 of the power against the start vector (10, 6, 3, 3).
    dot = 64'd10 * 64'(power[0]) + 64'd6 * 64'(power[1]) +
          64'd3 * 64'(power[2]) + 64'd3 * 64'(power[3]);
    return TERM_W'(dot % MODULUS);
  endfunction

  // ---------------------------------------------------------------------------
  // Idle and stall lengths: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Random index: mostly short exponents to keep the run fast, some mid-size,
  // a few at full width, and a handful at small indices 0 to 8.
  function automatic logic [INDEX_W-1:0] rand_index();
    logic [INDEX_W-1:0] v;
    int unsigned        r;
    int unsigned        w;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return INDEX_W'($urandom_range(0, 8));
    end else if (r < 60) begin
      w = $urandom_range(3, 12);
    end else if (r < 85) begin
      w = $urandom_range(13, 40);
    end else begin
      w = INDEX_W;
    end
    v = INDEX_W'({$urandom, $urandom});
    if (w < INDEX_W) begin
      v &= (INDEX_W'(1) << w) - INDEX_W'(1);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call, valid held until accepted.
  // ---------------------------------------------------------------------------

  task automatic send_index(input logic [INDEX_W-1:0] n);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    n_index_i  <= n;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid_i <= 1'b0;
  endtask

  // Output side: ready is dropped for random stretches, except while no_idle
  // is set, when every result is taken at once.
  always @(negedge clk) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold = 0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold = idle_len();
    end else begin
      out_ready_i <= 1'b1;
      ready_hold = $urandom_range(0, 20);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: records the expected term on every input transfer and checks
  // every output transfer against the oldest one.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    term_exp_t exp_item;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        exp_item.n    = n_index_i;
        exp_item.term = predict_term(n_index_i);
        expected_terms.push_back(exp_item);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_terms.size() == 0) begin
          $display("%0t: unexpected result term=%0d", $time, term_o);
          mismatch_cnt++;
        end else begin
          exp_item = expected_terms.pop_front();
          if (term_o !== exp_item.term) begin
            $display("%0t: n=%0d term expected %0d, got %0d", $time, exp_item.n,
                     exp_item.term, term_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Indices 0 to 4 bypass the matrix power; 5 to 8 are the first powered ones.
  task automatic test_direct_range();
    for (int i = 0; i <= 8; i++) begin
      send_index(INDEX_W'(i));
    end
    release_input();
  endtask

  // Widest exponents and single-bit exponents, all index bits at both values.
  task automatic test_index_extremes();
    send_index({INDEX_W{1'b1}});
    send_index(INDEX_W'(1) << (INDEX_W - 1));
    send_index((INDEX_W'(1) << (INDEX_W - 1)) + INDEX_W'(4));
    send_index(INDEX_W'(1) << 32);
    send_index(INDEX_W'(12));
    send_index({1'b0, {(INDEX_W-1){1'b1}}});
    send_index(INDEX_W'(64'h5555_5555_5555_5555));
    send_index(INDEX_W'(64'h2AAA_AAAA_AAAA_AAAA));
    release_input();
  endtask

  // Back-to-back transfers with the receiver always ready.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_index(INDEX_W'(3));
    send_index(INDEX_W'(100));
    send_index(INDEX_W'(0));
    send_index(INDEX_W'(4));
    send_index(INDEX_W'(1000));
    send_index(INDEX_W'(5));
    release_input();
    no_idle = 1'b0;
  endtask

  task automatic test_random_indices(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_index(rand_index());
    end
    release_input();
  endtask

  task automatic wait_drained();
    while (expected_terms.size() != 0) begin
      @(posedge clk);
    end
    // Allow a stray extra result to show up before the verdict.
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    n_index_i    = '0;
    no_idle      = 1'b0;
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;

    test_direct_range();
    test_index_extremes();
    test_back_to_back();
    test_random_indices(77);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, expected_terms.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ recurrence_term_by_matrix_power.f @@
rtl/rtbmp_pkg.sv
rtl/rtbmp_ram.sv
rtl/rtbmp_mont_mac.sv
rtl/recurrence_term_by_matrix_power.sv
sim/tb_recurrence_term_by_matrix_power.sv
